>>> rtl/fbc_pkg.sv
// shared types, constants and crc/header helpers for the frame builder
`default_nettype none
package fbc_pkg;

  localparam int LENGTH_BITS = 11;
  localparam int HEADER_BYTES = 14;
  localparam int HDR_IDX_BITS = 4;
  localparam logic [HDR_IDX_BITS-1:0] HEADER_LAST = HDR_IDX_BITS'(HEADER_BYTES - 1);
  localparam logic [HDR_IDX_BITS-1:0] CRC_LAST = HDR_IDX_BITS'(3);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 48;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_ADDRESS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_ADDRESS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROTOCOL_TYPE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PAYLOAD = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PAYLOAD = 3'd4;

  localparam logic [47:0] DEST_RESET = 48'h414243444546;
  localparam logic [47:0] SOURCE_RESET = 48'h474243444546;
  localparam logic [15:0] PTYPE_RESET = 16'h4742;
  localparam logic [LENGTH_BITS-1:0] MIN_RESET = LENGTH_BITS'(46);
  localparam logic [LENGTH_BITS-1:0] MAX_RESET = LENGTH_BITS'(1500);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_HEADER,
    CMD_PAYLOAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [47:0]            dest;
    logic [47:0]            src;
    logic [15:0]            ptype;
    logic [LENGTH_BITS-1:0] min_len;
    logic [LENGTH_BITS-1:0] max_len;
  } cfg_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] header_byte(input cfg_t cfg,
                                             input logic [HDR_IDX_BITS-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = cfg.dest[47:40];
      4'd1:    b = cfg.dest[39:32];
      4'd2:    b = cfg.dest[31:24];
      4'd3:    b = cfg.dest[23:16];
      4'd4:    b = cfg.dest[15:8];
      4'd5:    b = cfg.dest[7:0];
      4'd6:    b = cfg.src[47:40];
      4'd7:    b = cfg.src[39:32];
      4'd8:    b = cfg.src[31:24];
      4'd9:    b = cfg.src[23:16];
      4'd10:   b = cfg.src[15:8];
      4'd11:   b = cfg.src[7:0];
      4'd12:   b = cfg.ptype[15:8];
      4'd13:   b = cfg.ptype[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/fbc_front.sv
// front end: accepts input words, tracks the open frame and issues commands
`default_nettype none
module fbc_front
  import fbc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   kind,
  input  wire logic [LENGTH_BITS-1:0] pay_length,
  input  wire logic [7:0]             pay_byte,
  input  wire logic                   q_full,
  output logic                        push,
  output cmd_t                        push_cmd
);

  logic                   frame_open, frame_open_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic                   accept, bad_len, last_byte;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  // zero length is refused too, the crc tail needs a payload byte
  assign bad_len = (pay_length == '0) || (pay_length < cfg.min_len) ||
                   (pay_length > cfg.max_len);
  assign last_byte = (bytes_left == LENGTH_BITS'(1));

  always_comb begin
    push = 1'b0;
    push_cmd.kind = CMD_PAYLOAD;
    push_cmd.data = pay_byte;
    push_cmd.last = last_byte;
    frame_open_next = frame_open;
    bytes_left_next = bytes_left;
    if (accept) begin
      if (kind == KIND_START) begin
        push = 1'b1;
        push_cmd.kind = bad_len ? CMD_REJECT : CMD_HEADER;
        frame_open_next = !bad_len;
        bytes_left_next = bad_len ? '0 : pay_length;
      end else if (frame_open) begin
        push = 1'b1;
        bytes_left_next = bytes_left - LENGTH_BITS'(1);
        if (last_byte) begin
          frame_open_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= '0;
    end else begin
      frame_open <= frame_open_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fbc_queue.sv
// small command queue between front and back end
`default_nettype none
module fbc_queue
  import fbc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_cmd
);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_BITS-1:0] count, count_next;

  assign full = (count == QCOUNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCOUNT_BITS'(1);
    end else if (pop && !push) begin
      count_next = count - QCOUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fbc_back.sv
// back end: expands commands into header, payload, crc and reject words
`default_nettype none
module fbc_back
  import fbc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       q_valid,
  input  wire cmd_t       q_cmd,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            rejected,
  output logic            frame_end,
  output logic            run_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR = 2'd1;
  localparam logic [1:0] ST_CRC = 2'd2;

  logic [1:0]              state, state_next;
  logic [HDR_IDX_BITS-1:0] idx, idx_next;
  logic [31:0]             crc_value, crc_next;
  logic                    load, emit, e_rej, e_end, e_last;
  logic [7:0]              e_byte, hdr_b;

  // output register can take a new word
  assign load = !out_valid || out_ready;
  assign hdr_b = header_byte(cfg, idx);

  always_comb begin
    pop = 1'b0;
    emit = 1'b0;
    e_byte = 8'd0;
    e_rej = 1'b0;
    e_end = 1'b0;
    e_last = 1'b0;
    state_next = state;
    idx_next = idx;
    crc_next = crc_value;
    unique case (state)
      ST_IDLE: begin
        if (load && q_valid) begin
          pop = 1'b1;
          emit = 1'b1;
          case (q_cmd.kind)
            CMD_REJECT: begin
              e_rej = 1'b1;
              e_last = 1'b1;
              crc_next = CRC_INIT;
            end
            CMD_HEADER: begin
              e_byte = header_byte(cfg, '0);
              crc_next = crc_fold(CRC_INIT, e_byte);
              idx_next = HDR_IDX_BITS'(1);
              state_next = ST_HDR;
            end
            default: begin
              e_byte = q_cmd.data;
              crc_next = crc_fold(crc_value, q_cmd.data);
              if (q_cmd.last) begin
                idx_next = '0;
                state_next = ST_CRC;
              end else begin
                e_last = 1'b1;
              end
            end
          endcase
        end
      end
      ST_HDR: begin
        if (load) begin
          emit = 1'b1;
          e_byte = hdr_b;
          crc_next = crc_fold(crc_value, hdr_b);
          idx_next = idx + HDR_IDX_BITS'(1);
          if (idx == HEADER_LAST) begin
            e_last = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_CRC: begin
        if (load) begin
          emit = 1'b1;
          // least significant byte first
          e_byte = crc_value[{idx[1:0], 3'b000} +: 8];
          idx_next = idx + HDR_IDX_BITS'(1);
          if (idx == CRC_LAST) begin
            e_end = 1'b1;
            e_last = 1'b1;
            crc_next = CRC_INIT;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      crc_value <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      crc_value <= crc_next;
      if (load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      out_byte <= e_byte;
      rejected <= e_rej;
      frame_end <= e_end;
      run_last <= e_last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ethernet_frame_builder_crc32.sv
// Ethernet II style frame builder with reflected CRC-32: top level and config registers
//
// A start word (kind 0) with a length inside [min_payload, max_payload] (and not zero)
// yields the 14 header words; a length outside gives one word with rejected set. Each
// payload word (kind 1) of an open frame is passed through; the last one is followed
// by 4 CRC words, least significant byte first, frame_end on the final one. Payload
// words outside a frame are dropped and a new start abandons an open frame. Payload
// words move at one per cycle through the single output register unless stalled or
// busy with header or CRC words; a 4-entry command queue keeps the input flowing until
// it fills. The CRC folds one byte per cycle with no final inversion. Configuration is
// written via cfg_we/cfg_index/cfg_data; the user must do so while idle, unenforced.
`default_nettype none
module ethernet_frame_builder_crc32
  import fbc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      kind,
  input  wire logic [LENGTH_BITS-1:0]    pay_length,
  input  wire logic [7:0]                pay_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_byte,
  output logic                           rejected,
  output logic                           frame_end,
  output logic                           run_last
);

  cfg_t cfg;
  logic q_full, push, pop, q_valid;
  cmd_t push_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest <= DEST_RESET;
      cfg.src <= SOURCE_RESET;
      cfg.ptype <= PTYPE_RESET;
      cfg.min_len <= MIN_RESET;
      cfg.max_len <= MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_ADDRESS:   cfg.dest <= cfg_data[47:0];
        REG_SOURCE_ADDRESS: cfg.src <= cfg_data[47:0];
        REG_PROTOCOL_TYPE:  cfg.ptype <= cfg_data[15:0];
        REG_MIN_PAYLOAD:    cfg.min_len <= cfg_data[LENGTH_BITS-1:0];
        REG_MAX_PAYLOAD:    cfg.max_len <= cfg_data[LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  fbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .pay_length (pay_length),
    .pay_byte   (pay_byte),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  fbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  fbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .rejected  (rejected),
    .frame_end (frame_end),
    .run_last  (run_last)
  );

endmodule
`default_nettype wire

>>> bench/tb_ethernet_frame_builder_crc32.sv
// testbench for the ethernet frame builder: directed and random frames against a crc predictor
module tb_ethernet_frame_builder_crc32;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       rej;
    logic       fend;
    logic       last;
  } frame_word_t;

  class frame_scoreboard;
    logic [47:0]            dest;
    logic [47:0]            src;
    logic [15:0]            ptype;
    logic [LENGTH_BITS-1:0] min_len;
    logic [LENGTH_BITS-1:0] max_len;
    logic [31:0]            crc;
    logic [LENGTH_BITS-1:0] bytes_due;
    logic                   frame_live;
    frame_word_t            expected[$];
    int                     errors;

    function new();
      dest       = 48'h414243444546;
      src        = 48'h474243444546;
      ptype      = 16'h4742;
      min_len    = LENGTH_BITS'(46);
      max_len    = LENGTH_BITS'(1500);
      crc        = 32'hFFFFFFFF;
      bytes_due  = '0;
      frame_live = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
      case (idx)
        REG_DEST_ADDRESS:   dest = v[47:0];
        REG_SOURCE_ADDRESS: src = v[47:0];
        REG_PROTOCOL_TYPE:  ptype = v[15:0];
        REG_MIN_PAYLOAD:    min_len = v[LENGTH_BITS-1:0];
        REG_MAX_PAYLOAD:    max_len = v[LENGTH_BITS-1:0];
        default: ;
      endcase
    endfunction

    // bit-serial reflected update, lsb of the data first
    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        r = (r >> 1) ^ (32'hEDB88320 & {32{r[0] ^ d[i]}});
      end
      return r;
    endfunction

    function void push(logic [7:0] d, logic rj, logic fe, logic lw);
      frame_word_t w;
      w.data = d;
      w.rej  = rj;
      w.fend = fe;
      w.last = lw;
      expected.push_back(w);
    endfunction

    // returns the number of output words this input word causes
    function int note_word(logic k, logic [LENGTH_BITS-1:0] len, logic [7:0] b);
      logic [111:0] hdr;
      logic [7:0]   hb;
      if (k == KIND_START) begin
        frame_live = 1'b0;
        crc = 32'hFFFFFFFF;
        if (len == 0 || len < min_len || len > max_len) begin
          bytes_due = '0;
          push(8'h00, 1'b1, 1'b0, 1'b1);
          return 1;
        end
        hdr = {dest, src, ptype};
        for (int i = 0; i < 14; i++) begin
          hb = hdr[111 - 8 * i -: 8];
          crc = crc_step(crc, hb);
          push(hb, 1'b0, 1'b0, i == 13);
        end
        bytes_due = len;
        frame_live = 1'b1;
        return 14;
      end
      if (!frame_live) return 0;
      crc = crc_step(crc, b);
      bytes_due = bytes_due - 1'b1;
      if (bytes_due != 0) begin
        push(b, 1'b0, 1'b0, 1'b1);
        return 1;
      end
      push(b, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) begin
        push(crc[8 * i +: 8], 1'b0, i == 3, i == 3);
      end
      frame_live = 1'b0;
      crc = 32'hFFFFFFFF;
      return 5;
    endfunction

    function void report(string s);
      errors++;
      if (errors <= 100) $display("mismatch: %s", s);
    endfunction

    function void check_word(logic [7:0] ob, logic rj, logic fe, logic rl);
      frame_word_t w;
      if (expected.size() == 0) begin
        report($sformatf("unexpected word byte %h rej %b end %b last %b", ob, rj, fe, rl));
        return;
      end
      w = expected.pop_front();
      if (ob !== w.data) report($sformatf("out_byte %h, want %h", ob, w.data));
      if (rj !== w.rej) report($sformatf("rejected %b, want %b", rj, w.rej));
      if (fe !== w.fend) report($sformatf("frame_end %b, want %b", fe, w.fend));
      if (rl !== w.last) report($sformatf("run_last %b, want %b", rl, w.last));
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      kind;
  logic [LENGTH_BITS-1:0]    pay_length;
  logic [7:0]                pay_byte;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                out_byte;
  logic                      rejected;
  logic                      frame_end;
  logic                      run_last;

  frame_scoreboard sb = new();

  int burst_left = 0;
  int live_items = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_stall = 0;
  logic rx_next;

  ethernet_frame_builder_crc32 u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .pay_length (pay_length),
    .pay_byte   (pay_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .rejected   (rejected),
    .frame_end  (frame_end),
    .run_last   (run_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: sample at the edge, then pick the next ready value
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_word(out_byte, rejected, frame_end, run_last);
    end
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: rx_next = 1'b1;
      1: rx_next = ($urandom_range(0, 3) != 0);
      2: begin
        if (rx_stall > 0) begin
          rx_next = 1'b0;
          rx_stall--;
        end else begin
          rx_next = 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 8);
        end
      end
      default: rx_next = ((rx_cycle % 7) != 3);
    endcase
    out_ready <= rx_next;
  end

  task automatic apply_config(logic [47:0] d, logic [47:0] s, logic [15:0] p,
                              logic [LENGTH_BITS-1:0] mn, logic [LENGTH_BITS-1:0] mx);
    logic [CFG_INDEX_BITS-1:0] idx[5];
    logic [CFG_DATA_BITS-1:0]  val[5];
    idx = '{REG_DEST_ADDRESS, REG_SOURCE_ADDRESS, REG_PROTOCOL_TYPE,
            REG_MIN_PAYLOAD, REG_MAX_PAYLOAD};
    val = '{d, s, CFG_DATA_BITS'(p), CFG_DATA_BITS'(mn), CFG_DATA_BITS'(mx)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(logic k, logic [LENGTH_BITS-1:0] len, logic [7:0] b);
    int n;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 3)) @(posedge clk);
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
    end
    in_valid <= 1'b1;
    kind <= k;
    pay_length <= len;
    pay_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = sb.note_word(k, len, b);
    if (n > 0) live_items++;
    burst_left--;
  endtask

  task automatic send_start(logic [LENGTH_BITS-1:0] len);
    send_word(KIND_START, len, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(KIND_BYTE, LENGTH_BITS'($urandom), b);
  endtask

  // a zero length start rejects and leaves no frame open
  task automatic close_frame();
    if (sb.frame_live) send_start('0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [47:0] pick48();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [LENGTH_BITS-1:0] pick_len(int lo, int hi);
    int span;
    span = hi - lo;
    if ($urandom_range(0, 19) == 0) return LENGTH_BITS'(lo + $urandom_range(0, span > 40 ? 40 : span));
    return LENGTH_BITS'(lo + $urandom_range(0, span > 7 ? 7 : span));
  endfunction

  initial begin
    logic [47:0]            d;
    logic [LENGTH_BITS-1:0] mn;
    logic [LENGTH_BITS-1:0] mx;
    logic [LENGTH_BITS-1:0] len;
    int                     lo;
    int                     hi;
    int                     r;
    int                     cut;
    int                     target;
    int                     mode;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    kind <= KIND_START;
    pay_length <= '0;
    pay_byte <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset bounds: zero, too long, too short, stray word, abandoned frames
    send_start(LENGTH_BITS'(0));
    send_start(LENGTH_BITS'(2047));
    send_start(LENGTH_BITS'(45));
    send_byte(8'h5a);
    send_start(LENGTH_BITS'(46));
    send_byte(8'h00);
    send_byte(8'hff);
    send_start(LENGTH_BITS'(1500));
    send_byte(8'h12);
    send_start(LENGTH_BITS'(1501));
    wait_idle();

    apply_config('1, '0, '1, LENGTH_BITS'(1), LENGTH_BITS'(3));
    send_start(LENGTH_BITS'(1));
    send_byte(8'hff);
    send_start(LENGTH_BITS'(3));
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_start(LENGTH_BITS'(4));
    send_byte(8'h01);
    wait_idle();

    apply_config('0, '1, '0, LENGTH_BITS'(2047), LENGTH_BITS'(2047));
    send_start(LENGTH_BITS'(2047));
    send_byte(8'ha5);
    send_start(LENGTH_BITS'(2046));
    wait_idle();

    apply_config(pick48(), pick48(), pick16(), LENGTH_BITS'(0), LENGTH_BITS'(0));
    send_start(LENGTH_BITS'(0));
    send_start(LENGTH_BITS'(1));
    wait_idle();

    // crossed bounds reject everything
    apply_config(pick48(), pick48(), pick16(), LENGTH_BITS'(9), LENGTH_BITS'(3));
    send_start(LENGTH_BITS'(5));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 4;
      case (mode)
        0: begin
          mn = LENGTH_BITS'($urandom_range(1, 3));
          mx = mn + LENGTH_BITS'($urandom_range(0, 6));
          apply_config(pick48(), pick48(), pick16(), mn, mx);
        end
        1: apply_config(pick48(), pick48(), pick16(), '0, '1);
        2: begin
          mn = LENGTH_BITS'($urandom_range(2, 2047));
          mx = LENGTH_BITS'($urandom_range(0, mn - 1));
          apply_config(pick48(), pick48(), pick16(), mn, mx);
        end
        default: begin
          d = ph[2] ? '1 : '0;
          apply_config(d, ~d, ph[2] ? 16'hffff : 16'h0000, LENGTH_BITS'(1),
                       LENGTH_BITS'($urandom_range(1, 4)));
        end
      endcase
      lo = (sb.min_len == 0) ? 1 : sb.min_len;
      hi = sb.max_len;
      target = live_items + ((mode == 2) ? 10 : 60);
      while (live_items < target) begin
        r = $urandom_range(0, 99);
        if (lo <= hi && r < 75) begin
          len = pick_len(lo, hi);
          send_start(len);
          for (int j = 0; j < len; j++) send_byte(8'($urandom));
        end else if (lo <= hi && r < 85) begin
          // frame cut short, the next start drops it
          len = pick_len(lo, hi);
          cut = $urandom_range(0, len - 1);
          send_start(len);
          for (int j = 0; j < cut; j++) send_byte(8'($urandom));
        end else if (r < 93) begin
          send_start(LENGTH_BITS'($urandom));
        end else begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
      end
      close_frame();
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
